// ----- rtl/core/ordered_list_engine_macros.svh -----
// assertion macros for the ordered list engine
// used by the controller and datapath files; expects clk and rst_n in scope
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// checked only outside reset
`define OLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define OLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/ole_pkg.sv -----
// shared types and constants of the ordered list engine
// no dependencies; used by ole_ctrl, ole_dp and ordered_list_engine
`default_nettype none

package ole_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 8;
  localparam int CMP_W     = POS_W + 1;
  localparam int DATA_W    = 32;
  localparam int FPOS_W    = 7;
  localparam int COUNT_W   = 7;
  localparam int STAT_W    = 3;
  localparam int CMD_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DUMP   = 2'd3
  } ole_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } ole_status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SRCH = 2'd2,
    S_DUMP = 2'd3
  } ole_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic op_exec;
    logic match_en;
    logic srch_out;
    logic dump_out;
  } ole_ctl_t;

  // datapath to controller
  typedef struct packed {
    ole_cmd_t cmd;
    logic     empty;
    logic     dump_end;
    logic     slot_free;
  } ole_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/ole_ctrl.sv -----
// command sequencer of the ordered list engine
// depends on ole_pkg and ordered_list_engine_macros.svh
`default_nettype none

`include "ordered_list_engine_macros.svh"

module ole_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ole_pkg::ole_sts_t sts,
  output ole_pkg::ole_ctl_t      ctl
);

  ole_pkg::ole_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ole_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ole_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_nxt   = ole_pkg::S_EXEC;
        end
      end
      ole_pkg::S_EXEC: begin
        // search and dump of a non-empty list take their own states
        if (sts.cmd == ole_pkg::CMD_SEARCH && !sts.empty) begin
          ctl.match_en = 1'b1;
          state_nxt    = ole_pkg::S_SRCH;
        end else if (sts.cmd == ole_pkg::CMD_DUMP && !sts.empty) begin
          state_nxt = ole_pkg::S_DUMP;
        end else if (sts.slot_free) begin
          ctl.op_exec = 1'b1;
          state_nxt   = ole_pkg::S_IDLE;
        end
      end
      ole_pkg::S_SRCH: begin
        if (sts.slot_free) begin
          ctl.srch_out = 1'b1;
          state_nxt    = ole_pkg::S_IDLE;
        end
      end
      ole_pkg::S_DUMP: begin
        if (sts.slot_free) begin
          ctl.dump_out = 1'b1;
          if (sts.dump_end) begin
            state_nxt = ole_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ole_pkg::S_IDLE;
      end
    endcase
  end

  `OLE_ASSERT(a_ctl_onehot, $onehot0({ctl.capture, ctl.op_exec, ctl.match_en, ctl.srch_out, ctl.dump_out}), "more than one datapath command")
  `OLE_ASSERT(a_capture_then_exec, ctl.capture |=> state_r == ole_pkg::S_EXEC, "capture not followed by execute")
  `OLE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ole_pkg::S_IDLE, "controller not idle after reset")

endmodule

`default_nettype wire

// ----- rtl/core/ole_dp.sv -----
// datapath of the ordered list engine: entry cell chain, count, match vector
// and result register; depends on ole_pkg and ordered_list_engine_macros.svh
`default_nettype none

`include "ordered_list_engine_macros.svh"

module ole_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire ole_pkg::ole_ctl_t                    ctl,
  output ole_pkg::ole_sts_t                         sts,
  input  wire ole_pkg::ole_cmd_t                    in_cmd,
  input  wire logic        [ole_pkg::POS_W-1:0]     in_position,
  input  wire logic signed [ole_pkg::DATA_W-1:0]    in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output ole_pkg::ole_status_t                      out_status,
  output logic signed [ole_pkg::DATA_W-1:0]         out_data,
  output logic        [ole_pkg::FPOS_W-1:0]         out_fpos,
  output logic        [ole_pkg::COUNT_W-1:0]        out_count,
  output logic                                      out_last
);

  localparam int DEPTH  = ole_pkg::DEPTH;
  localparam int IDX_W  = ole_pkg::IDX_W;
  localparam int CNT_W  = ole_pkg::CNT_W;
  localparam int CMP_W  = ole_pkg::CMP_W;
  localparam int DATA_W = ole_pkg::DATA_W;
  localparam int POS_W  = ole_pkg::POS_W;
  localparam int FPOS_W = ole_pkg::FPOS_W;

  // captured command
  ole_pkg::ole_cmd_t          cmd_r;
  logic [POS_W-1:0]           pos_r;
  logic signed [DATA_W-1:0]   val_r;

  logic signed [DATA_W-1:0]   cells_r   [DEPTH];
  logic signed [DATA_W-1:0]   cells_nxt [DEPTH];
  logic [CNT_W-1:0]           occ_r, occ_nxt;
  logic [IDX_W-1:0]           ptr_r, ptr_nxt;
  logic [DEPTH-1:0]           match_r, match_nxt;

  logic                       out_valid_r, out_valid_nxt;
  ole_pkg::ole_status_t       status_r, status_nxt;
  logic signed [DATA_W-1:0]   data_r, data_nxt;
  logic [FPOS_W-1:0]          fpos_r, fpos_nxt;
  logic [ole_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                       last_r, last_nxt;

  logic [CMP_W-1:0]           pos_x, occ_x, pos_m1_x;
  logic [POS_W-1:0]           pos_m1;
  logic                       full, empty, ins_ok, del_ok, dump_end, slot_free, load;
  logic                       do_ins, do_del, found;
  logic [IDX_W-1:0]           rd_idx;
  logic signed [DATA_W-1:0]   rd_data;
  logic [FPOS_W-1:0]          fpos_enc;

  always_comb begin
    pos_x    = CMP_W'(pos_r);
    occ_x    = CMP_W'(occ_r);
    pos_m1   = pos_r - 1'b1;
    pos_m1_x = pos_x - CMP_W'(1);
    full     = (occ_r == CNT_W'(DEPTH));
    empty    = (occ_r == '0);
    ins_ok   = !full && (pos_x != '0) && (pos_x <= occ_x + CMP_W'(1));
    del_ok   = !empty && (pos_x != '0) && (pos_x <= occ_x);
    do_ins   = ctl.op_exec && (cmd_r == ole_pkg::CMD_INSERT) && ins_ok;
    do_del   = ctl.op_exec && (cmd_r == ole_pkg::CMD_DELETE) && del_ok;
    dump_end = (CNT_W'(ptr_r) == occ_r - CNT_W'(1));
    slot_free = !out_valid_r || out_ready;
    load     = ctl.op_exec || ctl.srch_out || ctl.dump_out;
    // single read port shared by delete and dump
    rd_idx   = ctl.dump_out ? ptr_r : pos_m1[IDX_W-1:0];
    rd_data  = cells_r[rd_idx];
  end

  // cell chain: insert shifts up from the position, delete shifts down into it
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (do_ins) begin
        if (CMP_W'(g) == pos_m1_x) begin
          cells_nxt[g] = val_r;
        end else if (CMP_W'(g) > pos_m1_x) begin
          if (g > 0) begin
            cells_nxt[g] = cells_r[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (do_del) begin
        if (CMP_W'(g) >= pos_m1_x && g < DEPTH - 1) begin
          cells_nxt[g] = cells_r[(g < DEPTH - 1) ? g + 1 : g];
        end
      end
    end
    assign match_nxt[g] = (cells_r[g] == val_r) && (CNT_W'(g) < occ_r);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
  end

  // lowest matching cell wins
  always_comb begin
    fpos_enc = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        fpos_enc = FPOS_W'(i + 1);
      end
    end
    found = |match_r;
  end

  always_comb begin
    occ_nxt = occ_r;
    if (do_ins) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (do_del) begin
      occ_nxt = occ_r - CNT_W'(1);
    end

    ptr_nxt = ptr_r;
    if (ctl.capture) begin
      ptr_nxt = '0;
    end else if (ctl.dump_out) begin
      ptr_nxt = dump_end ? '0 : ptr_r + IDX_W'(1);
    end

    status_nxt = status_r;
    data_nxt   = data_r;
    fpos_nxt   = fpos_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    if (ctl.op_exec) begin
      data_nxt  = '0;
      fpos_nxt  = '0;
      last_nxt  = 1'b1;
      count_nxt = ole_pkg::COUNT_W'(occ_nxt);
      case (cmd_r)
        ole_pkg::CMD_INSERT: begin
          status_nxt = full ? ole_pkg::ST_FULL :
                       (ins_ok ? ole_pkg::ST_OK : ole_pkg::ST_BADPOS);
        end
        ole_pkg::CMD_DELETE: begin
          status_nxt = empty ? ole_pkg::ST_EMPTY :
                       (del_ok ? ole_pkg::ST_OK : ole_pkg::ST_BADPOS);
          data_nxt   = del_ok ? rd_data : '0;
        end
        default: begin
          status_nxt = ole_pkg::ST_EMPTY;
        end
      endcase
    end else if (ctl.srch_out) begin
      status_nxt = found ? ole_pkg::ST_OK : ole_pkg::ST_NOTFOUND;
      data_nxt   = '0;
      fpos_nxt   = found ? fpos_enc : '0;
      last_nxt   = 1'b1;
      count_nxt  = ole_pkg::COUNT_W'(occ_r);
    end else if (ctl.dump_out) begin
      status_nxt = ole_pkg::ST_OK;
      data_nxt   = rd_data;
      fpos_nxt   = '0;
      last_nxt   = dump_end;
      count_nxt  = ole_pkg::COUNT_W'(occ_r);
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (ctl.match_en) begin
      match_r <= match_nxt;
    end
    status_r <= status_nxt;
    data_r   <= data_nxt;
    fpos_r   <= fpos_nxt;
    count_r  <= count_nxt;
    last_r   <= last_nxt;
  end

  assign sts.cmd       = cmd_r;
  assign sts.empty     = empty;
  assign sts.dump_end  = dump_end;
  assign sts.slot_free = slot_free;

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_fpos   = fpos_r;
  assign out_count  = count_r;
  assign out_last   = last_r;

  `OLE_ASSERT(a_occ_bound, occ_r <= CNT_W'(DEPTH), "entry count above depth")
  `OLE_ASSERT(a_load_free, load |-> slot_free, "result loaded over an unread word")
  `OLE_ASSERT(a_ins_count, do_ins |=> occ_r == $past(occ_r) + CNT_W'(1), "insert did not grow the list")
  `OLE_ASSERT(a_dump_wrap, (ctl.dump_out && dump_end) |=> (ptr_r == '0 && out_last), "dump end not marked")

endmodule

`default_nettype wire

// ----- rtl/core/ordered_list_engine.sv -----
// Ordered list engine: keeps up to DEPTH signed 32-bit entries in order.
// Input channel in_*: one command word per handshake. in_tuser carries the
// command (insert, delete, search, dump), in_tdata the position and value.
// Result channel out_*: insert, delete and search give one word; dump gives
// one word per entry (one word if the list is empty); out_tlast marks the
// final word of each command.
// Sequence: a command is captured in the idle state and worked on in the
// execute state, which for insert, delete and an empty-list command writes
// the result register behind out_tvalid. Search compares all cells in
// parallel into a match register in the execute state, then encodes the
// first match in the search state. Dump goes through the execute state to
// the dump state, then gives one entry a cycle, while the receiver does not
// stall, through the single read port of the cell chain. One command at a time.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; cell contents are kept but never read past the entry count.
// The result register frees the input side: the next command is taken
// while a result waits. If the receiver stalls, the word holds and the
// engine waits before writing the next result.
// Depends on ole_pkg, ole_ctrl and ole_dp.
`default_nettype none

module ordered_list_engine (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // position[7:0], value[39:8]
  input  wire logic [ole_pkg::IN_DATA_W-1:0]      in_tdata,
  // cmd[1:0]
  input  wire logic [ole_pkg::CMD_W-1:0]          in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // status[2:0], data_out[34:3], found_position[41:35], entry_count[48:42], zero pad
  output logic [ole_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                    out_tlast
);

  ole_pkg::ole_ctl_t                   ctl;
  ole_pkg::ole_sts_t                   sts;
  ole_pkg::ole_status_t                res_status;
  logic signed [ole_pkg::DATA_W-1:0]   res_data;
  logic [ole_pkg::FPOS_W-1:0]          res_fpos;
  logic [ole_pkg::COUNT_W-1:0]         res_count;

  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ole_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sts         (sts),
    .in_cmd      (ole_pkg::ole_cmd_t'(in_tuser)),
    .in_position (in_tdata[ole_pkg::POS_W-1:0]),
    .in_value    (in_tdata[ole_pkg::POS_W +: ole_pkg::DATA_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (res_status),
    .out_data    (res_data),
    .out_fpos    (res_fpos),
    .out_count   (res_count),
    .out_last    (out_tlast)
  );

  assign out_tdata = {7'd0, res_count, res_fpos, res_data, res_status};

endmodule

`default_nettype wire
